### rtl/gbc_pkg.sv
// Shared types, constants and the weight lookup for the Gaussian blur block.
// No dependencies; compile first.
package gbc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MAX_RADIUS_DEF = 3;

    localparam int CH_W       = 8;
    localparam int WT_W       = 16;
    localparam int WT_CNT     = 10;
    localparam int WT_BITS    = WT_CNT * WT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [1:0]  RST_RADIUS = 2'd1;
    localparam logic [63:0] RST_WT_LOW = 64'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_RADIUS  = 3'd2,
        REG_WT_LOW  = 3'd3,
        REG_WT_MID  = 3'd4,
        REG_WT_HIGH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // per-row control handed from the top to each window row
    typedef struct packed {
        logic shift;
        logic row_ok;
    } t_cell_ctl;

    // weight of the offset pair (max,min) of |a|,|b|; triangular index
    function automatic logic [WT_W-1:0] weight_for(input logic [WT_BITS-1:0] words,
                                                   input logic [2:0] a,
                                                   input logic [2:0] b);
        logic [2:0] big;
        logic [2:0] sml;
        logic [7:0] idx;
        big = (a > b) ? a : b;
        sml = (a > b) ? b : a;
        idx = ((8'(big) * (8'(big) + 8'd1)) >> 1) + 8'(sml);
        if (idx < 8'(WT_CNT)) begin
            return words[{idx[3:0], 4'b0000} +: WT_W];
        end
        return '0;
    endfunction

endpackage

### rtl/gbc_if.sv
// Stream and configuration channel interfaces of the blur block.
// Depends on gbc_pkg.
interface gbc_pix_if;
    import gbc_pkg::*;
    logic            valid;
    logic            ready;
    logic            is_fill;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    modport source (output valid, is_fill, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, is_fill, in_red, in_green, in_blue, output ready);
endinterface

interface gbc_out_if;
    import gbc_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last_of_frame;
    modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

interface gbc_cfg_if;
    import gbc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/gbc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

### rtl/gbc_cell.sv
// One window row: shift line of pixels, weighted products and row sum.
// Depends on gbc_pkg.
module gbc_cell #(
    parameter int MAX_RADIUS = gbc_pkg::MAX_RADIUS_DEF,
    localparam int TAPS      = 2 * MAX_RADIUS + 1,
    localparam int PROD_W    = gbc_pkg::CH_W + gbc_pkg::WT_W,
    localparam int SUM_W     = PROD_W + $clog2(TAPS)
) (
    input  logic                                i_clk,
    input  gbc_pkg::t_cell_ctl                  i_ctl,
    input  gbc_pkg::t_pixel                     i_pix,
    input  logic [TAPS-1:0]                     i_col_ok,
    input  logic [TAPS-1:0][gbc_pkg::WT_W-1:0]  i_wt,
    output logic [2:0][SUM_W-1:0]               o_sum
);
    import gbc_pkg::*;

    t_pixel            r_win  [TAPS];
    logic [PROD_W-1:0] r_prod [TAPS][3];
    logic [2:0][SUM_W-1:0] n_sum;

    // newest pixel at tap 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win[0] <= i_pix;
            for (int j = 1; j < TAPS; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    // masked weight zeroes neighbors outside the image
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TAPS; j++) begin
            if (i_ctl.row_ok && i_col_ok[j]) begin
                r_prod[j][0] <= PROD_W'(r_win[j].red)   * PROD_W'(i_wt[j]);
                r_prod[j][1] <= PROD_W'(r_win[j].green) * PROD_W'(i_wt[j]);
                r_prod[j][2] <= PROD_W'(r_win[j].blue)  * PROD_W'(i_wt[j]);
            end else begin
                r_prod[j][0] <= '0;
                r_prod[j][1] <= '0;
                r_prod[j][2] <= '0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = '0;
            for (int j = 0; j < TAPS; j++) begin
                n_sum[c] = n_sum[c] + SUM_W'(r_prod[j][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_sum <= n_sum;
    end
endmodule

### rtl/gaussian_blur_convolution_top.sv
// Top level of the streaming RGB Gaussian blur.
// Depends on gbc_pkg, gbc_if, gbc_ram and gbc_cell.
//
// Usage:
//  - i_pix takes pixels in raster order, one beat per pixel. After the last
//    pixel of a frame, send R*W+R beats with is_fill set to flush the tail;
//    fills sent inside a frame are dropped.
//  - o_pix gives one blurred pixel per output beat, last_of_frame on the
//    final one. Pixel k comes out after input beat k+R*W+R is accepted.
//  - i_cfg writes registers 0..5 (width, height, radius, three weight words);
//    write only while the block is idle. ready is always high; i_pix.ready
//    drops for the cycle after a write while the derived geometry settles.
//  - Throughput: one beat per clock while i_pix.ready is high. An accepted
//    beat passes the RAM read, window shift, products, row sums, column sum,
//    then the output queue write, in that order, before it reaches o_pix.
//  - The window is 2*MAX_RADIUS+1 cells, one per window row; line storage is
//    one RAM, MAX_WIDTH deep, holding 2*MAX_RADIUS pixels per word.
//  - Reset clears the counters and the output queue and restores register
//    defaults. The line RAM needs no clearing: rows outside the frame are
//    masked.
//  - A stalled receiver fills the 8-entry output queue; i_pix.ready drops
//    once the queue holds more than two results, so nothing is lost.
module gaussian_blur_convolution_top #(
    parameter int MAX_WIDTH  = gbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gbc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = gbc_pkg::MAX_RADIUS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gbc_pix_if.sink   i_pix,
    gbc_out_if.source o_pix,
    gbc_cfg_if.sink   i_cfg
);
    import gbc_pkg::*;

    localparam int TAPS     = 2 * MAX_RADIUS + 1;
    localparam int LB       = 2 * MAX_RADIUS;
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int TOT_W    = WID_W + HGT_W;
    localparam int IP_W     = TOT_W + 1;
    localparam int PROD_W   = CH_W + WT_W;
    localparam int SUM_W    = PROD_W + $clog2(TAPS);
    localparam int ACC_W    = SUM_W + $clog2(TAPS);
    localparam int PIX_W    = $bits(t_pixel);
    localparam int FIFO_D   = 8;
    localparam int FIFO_AW  = $clog2(FIFO_D);
    localparam int PIPE_N   = 5;
    localparam int RDY_MAX  = FIFO_D - PIPE_N - 1;

    // ---------------- configuration registers ----------------
    logic [10:0]  r_cfg_width;
    logic [12:0]  r_cfg_height;
    logic [1:0]   r_cfg_radius;
    logic [63:0]  r_wt_low;
    logic [63:0]  r_wt_mid;
    logic [31:0]  r_wt_high;
    logic         r_cfg_wait;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_radius <= RST_RADIUS;
            r_wt_low     <= RST_WT_LOW;
            r_wt_mid     <= '0;
            r_wt_high    <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_WIDTH:   r_cfg_width  <= i_cfg.data[10:0];
                REG_HEIGHT:  r_cfg_height <= i_cfg.data[12:0];
                REG_RADIUS:  r_cfg_radius <= i_cfg.data[1:0];
                REG_WT_LOW:  r_wt_low     <= i_cfg.data;
                REG_WT_MID:  r_wt_mid     <= i_cfg.data;
                REG_WT_HIGH: r_wt_high    <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // hold off input in the cycle after a write so the derived registers see it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wait <= 1'b0;
        end else begin
            r_cfg_wait <= i_cfg.valid && i_cfg.ready;
        end
    end

    // clamped geometry, frame size, output delay and the weight grid
    logic [WID_W-1:0] c_w;
    logic [HGT_W-1:0] c_h;
    logic [RAD_W-1:0] c_r;
    logic [WID_W-1:0] r_w;
    logic [HGT_W-1:0] r_h;
    logic [RAD_W-1:0] r_r;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] r_delay;
    logic [TAPS-1:0][TAPS-1:0][WT_W-1:0] n_wt;
    logic [TAPS-1:0][TAPS-1:0][WT_W-1:0] r_wt;

    always_comb begin
        c_w = (r_cfg_width == '0) ? WID_W'(1) :
              (int'(r_cfg_width) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(r_cfg_width);
        c_h = (r_cfg_height == '0) ? HGT_W'(1) :
              (int'(r_cfg_height) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(r_cfg_height);
        c_r = (int'(r_cfg_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_cfg_radius);
    end

    always_comb begin
        int dr;
        int dc;
        for (int t = 0; t < TAPS; t++) begin
            for (int j = 0; j < TAPS; j++) begin
                dr = t - int'(c_r);
                dc = j - int'(c_r);
                if (dr < 0) dr = -dr;
                if (dc < 0) dc = -dc;
                if (t > 2 * int'(c_r) || j > 2 * int'(c_r)) begin
                    n_wt[t][j] = '0;
                end else begin
                    n_wt[t][j] = weight_for({r_wt_high, r_wt_mid, r_wt_low}, 3'(dr), 3'(dc));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= c_w;
        r_h     <= c_h;
        r_r     <= c_r;
        r_total <= TOT_W'(c_w) * TOT_W'(c_h);
        r_delay <= TOT_W'(c_r) * TOT_W'(c_w) + TOT_W'(c_r);
        r_wt    <= n_wt;
    end

    // ---------------- input side: frame counters ----------------
    logic [IP_W-1:0]  r_ip;
    logic [TOT_W-1:0] r_lin;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_ptr;

    logic             acc;
    logic             frame_over;
    logic             in_frame;
    logic             adv;
    logic             emit;
    logic             last;
    logic [IP_W-1:0]  ip_next;
    logic [TAPS-1:0]  rmask;
    logic [TAPS-1:0]  cmask;
    t_pixel           new_pix;

    logic [FIFO_AW:0] r_count;

    assign i_pix.ready = (r_count <= (FIFO_AW+1)'(RDY_MAX)) && !r_cfg_wait;
    assign acc         = i_pix.valid && i_pix.ready;
    assign frame_over  = (r_lin >= r_total);
    assign in_frame    = (r_ip < IP_W'(r_total));
    // a pixel after the frame counts as a filler and still advances the window
    assign adv         = acc && !frame_over && (!in_frame || !i_pix.is_fill);
    assign ip_next     = r_ip + IP_W'(1);
    assign emit        = adv && (ip_next >= IP_W'(r_lin) + IP_W'(r_delay) + IP_W'(1));
    assign last        = ((r_lin + TOT_W'(1)) == r_total);

    always_comb begin
        if (in_frame) begin
            new_pix = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};
        end else begin
            new_pix = '0;
        end
    end

    // neighbor validity: row tap t is offset R-t, column tap j is offset R-j
    always_comb begin
        int x;
        int y;
        x = int'(r_row) + int'(r_r);
        y = int'(r_col) + int'(r_r);
        for (int t = 0; t < TAPS; t++) begin
            rmask[t] = (x >= t) && ((x - t) < int'(r_h));
            cmask[t] = (y >= t) && ((y - t) < int'(r_w));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip  <= '0;
            r_lin <= '0;
            r_row <= '0;
            r_col <= '0;
            r_ptr <= '0;
        end else if (acc) begin
            if (frame_over) begin
                r_ip  <= '0;
                r_lin <= '0;
                r_row <= '0;
                r_col <= '0;
                r_ptr <= '0;
            end else if (adv) begin
                r_ip <= ip_next;
                if (WID_W'(r_ptr) == r_w - WID_W'(1)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + COL_W'(1);
                end
                if (emit) begin
                    if (last) begin
                        r_ip  <= '0;
                        r_lin <= '0;
                        r_row <= '0;
                        r_col <= '0;
                        r_ptr <= '0;
                    end else begin
                        r_lin <= r_lin + TOT_W'(1);
                        if (WID_W'(r_col) == r_w - WID_W'(1)) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
            end
        end
    end

    // ---------------- stage 0: line RAM read ----------------
    logic             r_s0_adv;
    logic             r_s0_emit;
    logic             r_s0_last;
    logic [TAPS-1:0]  r_s0_rmask;
    logic [TAPS-1:0]  r_s0_cmask;
    t_pixel           r_s0_pix;
    logic [COL_W-1:0] r_s0_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_adv  <= 1'b0;
            r_s0_emit <= 1'b0;
        end else begin
            r_s0_adv  <= adv;
            r_s0_emit <= emit;
        end
        r_s0_last  <= last;
        r_s0_rmask <= rmask;
        r_s0_cmask <= cmask;
        r_s0_pix   <= new_pix;
        r_s0_ptr   <= r_ptr;
    end

    // each RAM word is one column: pixels p-W .. p-2M*W at column pointer
    t_pixel [LB-1:0] ram_q;
    t_pixel [LB-1:0] col_rd;
    t_pixel [LB-1:0] wr_col;
    t_pixel          col_in [TAPS];
    logic            r_byp;
    t_pixel [LB-1:0] r_byp_data;

    gbc_ram #(
        .WIDTH (LB * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s0_adv),
        .i_waddr (r_s0_ptr),
        .i_wdata (wr_col),
        .i_re    (adv),
        .i_raddr (r_ptr),
        .o_rdata (ram_q)
    );

    // same-address write and read in one cycle (one-pixel rows) forward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= adv && r_s0_adv && (r_s0_ptr == r_ptr);
        end
        r_byp_data <= wr_col;
    end

    always_comb begin
        col_rd    = r_byp ? r_byp_data : ram_q;
        col_in[0] = r_s0_pix;
        wr_col[0] = r_s0_pix;
        for (int t = 1; t < TAPS; t++) begin
            col_in[t] = col_rd[t-1];
        end
        for (int t = 1; t < LB; t++) begin
            wr_col[t] = col_rd[t-1];
        end
    end

    // ---------------- window cells ----------------
    logic             r_s1_emit;
    logic             r_s1_last;
    logic [TAPS-1:0]  r_s1_rmask;
    logic [TAPS-1:0]  r_s1_cmask;
    logic             r_s2_emit;
    logic             r_s2_last;
    logic             r_s3_emit;
    logic             r_s3_last;
    logic             r_s4_emit;
    logic             r_s4_last;

    logic [2:0][SUM_W-1:0] row_sum [TAPS];

    for (genvar t = 0; t < TAPS; t++) begin : g_cell
        t_cell_ctl ctl;
        assign ctl = '{shift: r_s0_adv, row_ok: r_s1_rmask[t]};
        gbc_cell #(
            .MAX_RADIUS (MAX_RADIUS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_pix    (col_in[t]),
            .i_col_ok (r_s1_cmask),
            .i_wt     (r_wt[t]),
            .o_sum    (row_sum[t])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_emit <= 1'b0;
            r_s2_emit <= 1'b0;
            r_s3_emit <= 1'b0;
            r_s4_emit <= 1'b0;
        end else begin
            r_s1_emit <= r_s0_emit;
            r_s2_emit <= r_s1_emit;
            r_s3_emit <= r_s2_emit;
            r_s4_emit <= r_s3_emit;
        end
        r_s1_last  <= r_s0_last;
        r_s1_rmask <= r_s0_rmask;
        r_s1_cmask <= r_s0_cmask;
        r_s2_last  <= r_s1_last;
        r_s3_last  <= r_s2_last;
        r_s4_last  <= r_s3_last;
    end

    // column sum over the row cells
    logic [2:0][ACC_W-1:0] n_acc;
    logic [2:0][ACC_W-1:0] r_acc;
    logic [2:0][CH_W-1:0]  sat;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = '0;
            for (int t = 0; t < TAPS; t++) begin
                n_acc[c] = n_acc[c] + ACC_W'(row_sum[t][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // drop the 16 fraction bits, saturate at full scale
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if ((r_acc[c] >> WT_W) > ACC_W'(255)) begin
                sat[c] = '1;
            end else begin
                sat[c] = r_acc[c][WT_W +: CH_W];
            end
        end
    end

    // ---------------- output queue ----------------
    typedef struct packed {
        logic   last;
        t_pixel pix;
    } t_result;

    t_result            r_fifo [FIFO_D];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic               pop;

    assign pop = o_pix.valid && o_pix.ready;

    // channel 0 is red, 1 green, 2 blue
    always_ff @(posedge i_clk) begin
        if (r_s4_emit) begin
            r_fifo[r_wr_ptr] <= '{last: r_s4_last,
                                  pix: '{red: sat[0], green: sat[1], blue: sat[2]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s4_emit) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (r_s4_emit && !pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (pop && !r_s4_emit) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    assign o_pix.valid         = (r_count != '0);
    assign o_pix.out_red       = r_fifo[r_rd_ptr].pix.red;
    assign o_pix.out_green     = r_fifo[r_rd_ptr].pix.green;
    assign o_pix.out_blue      = r_fifo[r_rd_ptr].pix.blue;
    assign o_pix.last_of_frame = r_fifo[r_rd_ptr].last;

endmodule

### sim/gbc_tb_if.sv
`timescale 1ns / 1ps
// Testbench copy point for the blur channel interfaces.
// The interfaces themselves live in rtl/gbc_if.sv; this file only holds shared TB types.
// Depends on gbc_pkg.
package gbc_tb_pkg;
    import gbc_pkg::*;

    typedef struct {
        logic       is_fill;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_beat;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_beat;
endpackage

### sim/tb_gaussian_blur_convolution_top.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_blur_convolution_top: frames of random size,
// radius and weights stream through with random gaps; an in-bench blur predictor
// checks every output beat. Depends on gbc_pkg, gbc_if, gbc_tb_pkg and the RTL.
module tb_gaussian_blur_convolution_top;
    import gbc_pkg::*;
    import gbc_tb_pkg::*;

    localparam int RING = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    gbc_pix_if pix_in ();
    gbc_out_if pix_out ();
    gbc_cfg_if cfg ();

    gaussian_blur_convolution_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in.sink),
        .o_pix  (pix_out.source),
        .i_cfg  (cfg.sink)
    );

    // predictor state: registers and stream position
    logic [10:0]  m_width;
    logic [12:0]  m_height;
    logic [1:0]   m_radius;
    logic [159:0] m_weights;
    logic [23:0]  line_ring [RING];
    int unsigned  in_pos, out_row, out_col;

    t_in_beat  pending_beats[$];
    t_out_beat blurred_expect[$];

    int mismatches;
    int beats_out;
    int frames_done;
    int idle_cycles;
    int items_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] kernel_weight(int a, int b);
        int big, sml, idx;
        big = (a > b) ? a : b;
        sml = (a > b) ? b : a;
        idx = big * (big + 1) / 2 + sml;
        return m_weights[idx*16 +: 16];
    endfunction

    function automatic logic [7:0] sat8(longint unsigned sum);
        longint unsigned v;
        v = sum >> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // one accepted input beat through the blur predictor
    task automatic blur_step(t_in_beat b);
        int unsigned w, h, r, total, delay, lin, orow, ocol;
        longint unsigned sr, sg, sb;
        int nr, nc;
        logic [23:0] px;
        logic [15:0] wt;
        t_out_beat o;
        w = (m_width == 0) ? 1 : ((m_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : m_width);
        h = (m_height == 0) ? 1 : ((m_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : m_height);
        r = m_radius;
        total = w * h;
        delay = r * w + r;
        lin = out_row * w + out_col;
        sr = 0; sg = 0; sb = 0;
        if (lin >= total) begin
            in_pos = 0; out_row = 0; out_col = 0;
            return;
        end
        if (in_pos < total) begin
            if (b.is_fill) return;
            line_ring[in_pos % RING] = {b.red, b.green, b.blue};
        end
        in_pos++;
        if (in_pos < lin + delay + 1) return;
        orow = lin / w;
        ocol = lin % w;
        for (int dr = -int'(r); dr <= int'(r); dr++) begin
            nr = int'(orow) + dr;
            if (nr < 0 || nr >= int'(h)) continue;
            for (int dc = -int'(r); dc <= int'(r); dc++) begin
                nc = int'(ocol) + dc;
                if (nc < 0 || nc >= int'(w)) continue;
                px = line_ring[(nr * w + nc) % RING];
                wt = kernel_weight(dr < 0 ? -dr : dr, dc < 0 ? -dc : dc);
                sr += px[23:16] * wt;
                sg += px[15:8] * wt;
                sb += px[7:0] * wt;
            end
        end
        o.red = sat8(sr);
        o.green = sat8(sg);
        o.blue = sat8(sb);
        o.last = (lin + 1 == total);
        blurred_expect.push_back(o);
        lin++;
        if (lin >= total) begin
            in_pos = 0; out_row = 0; out_col = 0;
        end else begin
            out_row = lin / w;
            out_col = lin % w;
        end
    endtask

    // input driver: random gap before each beat, back to back on a zero gap
    int in_gap;
    always @(posedge i_clk) begin
        int gap;
        gap = in_gap;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                blur_step(pending_beats.pop_front());
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (!pix_in.valid || pix_in.ready) begin
                if (gap == 0 && pending_beats.size() > 0) begin
                    pix_in.valid    <= 1'b1;
                    pix_in.is_fill  <= pending_beats[0].is_fill;
                    pix_in.in_red   <= pending_beats[0].red;
                    pix_in.in_green <= pending_beats[0].green;
                    pix_in.in_blue  <= pending_beats[0].blue;
                end else begin
                    pix_in.valid <= 1'b0;
                    if (gap > 0) gap--;
                end
            end
            in_gap <= gap;
        end
    end

    // output monitor with random back-pressure
    int out_stall;
    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                beats_out++;
                if (blurred_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat %0h %0h %0h last=%0b",
                                 pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                                 pix_out.last_of_frame);
                end else begin
                    e = blurred_expect.pop_front();
                    if (e.last) frames_done++;
                    if (pix_out.out_red !== e.red || pix_out.out_green !== e.green ||
                        pix_out.out_blue !== e.blue || pix_out.last_of_frame !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: expected %0h %0h %0h last=%0b, got %0h %0h %0h last=%0b",
                                     beats_out, e.red, e.green, e.blue, e.last,
                                     pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                                     pix_out.last_of_frame);
                    end
                end
            end
            // each output beat: draw a stall; stall stretches off a quarter of the time
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                pix_out.ready <= 1'b0;
            end else if (pix_out.valid && pix_out.ready) begin
                if ($urandom_range(0, 3) != 0) begin
                    out_stall <= $urandom_range(0, 15);
                    pix_out.ready <= 1'b0;
                end else begin
                    pix_out.ready <= 1'b1;
                end
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat accepted anywhere
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("gaussian_blur_convolution_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_WIDTH:   m_width   = value[10:0];
            REG_HEIGHT:  m_height  = value[12:0];
            REG_RADIUS:  m_radius  = value[1:0];
            REG_WT_LOW:  m_weights[63:0]    = value;
            REG_WT_MID:  m_weights[127:64]  = value;
            REG_WT_HIGH: m_weights[159:128] = value[31:0];
            default: ;
        endcase
        cfg.valid <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    // wait for all predicted beats, then let the pipeline drain
    task automatic drain();
        while (pending_beats.size() > 0 || pix_in.valid || blurred_expect.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan(int mode);
        case (mode)
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // queue one frame plus its tail fills; optional stray fills and extra pixels
    task automatic queue_frame(int w, int h, int r, int chan_mode, bit noise);
        t_in_beat b;
        for (int k = 0; k < w * h; k++) begin
            if (noise && $urandom_range(0, 9) == 0) begin
                b.is_fill = 1'b1;
                b.red = rand_chan(2); b.green = rand_chan(2); b.blue = rand_chan(2);
                pending_beats.push_back(b);
                items_sent++;
            end
            b.is_fill = 1'b0;
            b.red = rand_chan(chan_mode); b.green = rand_chan(chan_mode);
            b.blue = rand_chan(chan_mode);
            pending_beats.push_back(b);
            items_sent++;
        end
        for (int k = 0; k < r * w + r; k++) begin
            // a pixel in the tail counts as a fill
            b.is_fill = (noise && $urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
            b.red = rand_chan(2); b.green = rand_chan(2); b.blue = rand_chan(2);
            pending_beats.push_back(b);
            items_sent++;
        end
    endtask

    task automatic run_frame(int w, int h, int r, logic [63:0] lo, logic [63:0] mid,
                             logic [31:0] hi, int chan_mode, bit noise);
        int cw;
        cw = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_HEIGHT, 64'(h));
        write_reg(REG_RADIUS, 64'(r));
        write_reg(REG_WT_LOW, lo);
        write_reg(REG_WT_MID, mid);
        write_reg(REG_WT_HIGH, {32'($urandom), hi});
        queue_frame(cw, h, r, chan_mode, noise);
        drain();
    endtask

    int w, h, r;

    initial begin
        i_rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.is_fill = 1'b0;
        pix_in.in_red = '0;
        pix_in.in_green = '0;
        pix_in.in_blue = '0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_WIDTH;
        cfg.data = '0;
        m_width = RST_WIDTH;
        m_height = RST_HEIGHT;
        m_radius = RST_RADIUS;
        m_weights = {96'd0, RST_WT_LOW};
        in_pos = 0; out_row = 0; out_col = 0;
        mismatches = 0; beats_out = 0; frames_done = 0; idle_cycles = 0;
        items_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: single pixel with radius 0, all-ones weight
        run_frame(1, 1, 0, 64'hFFFF, 64'h0, 32'h0, 1, 0);
        // saturating weights, white frame, full radius
        run_frame(3, 3, 3, '1, '1, '1, 1, 0);
        // black frame with max radius, stray fills in frame
        run_frame(4, 2, 3, 64'h1000_2000_3000_4000, 64'h0100_0200_0300_0400,
                  32'h0050_0060, 0, 1);
        // radius 1, centre weight only: output is input times 0xFFFF/0x10000, truncated
        run_frame(3, 2, 1, 64'hFFFF, 64'h0, 32'h0, 2, 1);
        // width 0 clamps to 1; radius 2 column
        run_frame(0, 4, 2, 64'h0, 64'h0, 32'h0, 2, 0);

        // random frames, mostly small, a few wider rows
        while (items_sent < 350) begin
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(9, 48);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            r = $urandom_range(0, 3);
            run_frame(w, h, r, {$urandom, $urandom}, {$urandom, $urandom},
                      ($urandom_range(0, 1) ? $urandom : 32'h0), 2, $urandom_range(0, 1));
        end
        // tall single column at full radius
        run_frame(1, 40, 3, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2, 0);

        $display("sent %0d input beats, checked %0d output beats over %0d frames",
                 items_sent, beats_out, frames_done);
        $display("radius 0..3, widths 0..48 with zero clamped, stray fills and tail pixels");
        if (mismatches == 0)
            $display("gaussian_blur_convolution_top: match");
        else
            $display("gaussian_blur_convolution_top: mismatch");
        $finish;
    end
endmodule
